// File: hdl/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

  // Character codes the editor reacts to or echoes.
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_ONE      = 8'h31;

  // Reset values of the configuration registers.
  localparam logic [7:0] TERM_CHAR_RST = 8'd13;
  localparam logic [7:0] MAX_LEN_RST   = 8'd64;

  // Configuration register indexes.
  localparam logic CFG_TERM_CHAR = 1'b0;
  localparam logic CFG_MAX_LEN   = 1'b1;

  // Line status as reported on every result.
  typedef enum logic [1:0] {
    ST_COLLECT  = 2'd0,
    ST_DONE     = 2'd1,
    ST_OVERFLOW = 2'd2
  } line_status_e;

  // Work orders handed from the front to the back.
  typedef enum logic [2:0] {
    OP_EMPTY,
    OP_TERM,
    OP_BACK,
    OP_CHAR,
    OP_OVFL
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic [1:0] status;
    logic       last;
  } out_t;

  typedef struct packed {
    op_e          op;
    logic [7:0]   data;
    logic [7:0]   index;
    line_status_e status;
  } cmd_t;

endpackage

// File: hdl/sle_front.sv
`timescale 1ns / 1ps

module sle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              accept_i,
  input  sle_pkg::in_t      in_i,
  output sle_pkg::cmd_t     cmd_o
);
  import sle_pkg::*;

  logic [7:0]   term_char_q, max_len_q;
  logic         finished_q, finished_d;
  logic [7:0]   pos_q, pos_d;
  logic [7:0]   prev_q, prev_d;
  line_status_e status_q, status_d;
  logic         is_back, is_plain, fits;
  logic [7:0]   b;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_char_q <= TERM_CHAR_RST;
      max_len_q   <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TERM_CHAR: term_char_q <= cfg_wdata_i;
        CFG_MAX_LEN:   max_len_q   <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Classification of the received byte.
  assign b        = in_i.rx_byte;
  assign is_back  = (b == CH_BS) || (b == CH_DEL) || ((prev_q == CH_LBRACKET) && (b == CH_D));
  assign is_plain = (b != CH_LBRACKET) && (b != CH_BS) && (b != CH_DEL);
  assign fits     = ({1'b0, pos_q} + 9'd1) < {1'b0, max_len_q};

  // Line state update and the order for the back end.
  always_comb begin
    finished_d   = finished_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    status_d     = status_q;
    cmd_o.op     = OP_EMPTY;
    cmd_o.data   = b;
    cmd_o.index  = pos_q;
    if (in_i.kind) begin
      finished_d = 1'b0;
      pos_d      = '0;
      prev_d     = '0;
      status_d   = ST_COLLECT;
    end else if (!finished_q) begin
      prev_d = b;
      if (b == CH_ESC) begin
        pos_d    = '0;
        status_d = ST_COLLECT;
      end else if (b == term_char_q) begin
        finished_d = 1'b1;
        status_d   = ST_DONE;
        cmd_o.op   = OP_TERM;
      end else if (is_back && (pos_q != '0)) begin
        pos_d    = pos_q - 8'd1;
        cmd_o.op = OP_BACK;
      end else if (is_plain) begin
        if (fits) begin
          pos_d    = pos_q + 8'd1;
          cmd_o.op = OP_CHAR;
        end else begin
          finished_d = 1'b1;
          status_d   = ST_OVERFLOW;
          cmd_o.op   = OP_OVFL;
        end
      end
    end
    cmd_o.status = status_d;
  end

  // State registers change only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b0;
      pos_q      <= '0;
      prev_q     <= '0;
      status_q   <= ST_COLLECT;
    end else if (accept_i) begin
      finished_q <= finished_d;
      pos_q      <= pos_d;
      prev_q     <= prev_d;
      status_q   <= status_d;
    end
  end

endmodule

// File: hdl/sle_cmd_fifo.sv
`timescale 1ns / 1ps

module sle_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sle_pkg::cmd_t  data_i,
  input  logic           pop_i,
  output sle_pkg::cmd_t  data_o,
  output logic           full_o,
  output logic           empty_o
);
  import sle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/sle_back.sv
`timescale 1ns / 1ps

module sle_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  sle_pkg::cmd_t  head_i,
  output logic           head_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sle_pkg::out_t  out_o
);
  import sle_pkg::*;

  logic [1:0] beat_q, beat_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, res;
  logic       load;

  // Expand the order at the queue head into its current result beat.
  always_comb begin
    res             = '0;
    res.status      = head_i.status;
    res.last        = 1'b1;
    case (head_i.op)
      OP_TERM: begin
        res.store_valid = 1'b1;
        res.store_index = head_i.index;
      end
      OP_CHAR: begin
        res.echo_valid  = 1'b1;
        res.echo_byte   = head_i.data;
        res.store_valid = 1'b1;
        res.store_index = head_i.index;
        res.store_byte  = head_i.data;
      end
      OP_OVFL: begin
        res.store_valid = 1'b1;
        res.store_index = head_i.index;
        if (beat_q == 2'd0) begin
          res.echo_valid = 1'b1;
          res.echo_byte  = head_i.data;
          res.store_byte = head_i.data;
          res.last       = 1'b0;
        end
      end
      OP_BACK: begin
        res.echo_valid = 1'b1;
        res.last       = (beat_q == 2'd3);
        case (beat_q)
          2'd0:    res.echo_byte = CH_ESC;
          2'd1:    res.echo_byte = CH_LBRACKET;
          2'd2:    res.echo_byte = CH_ONE;
          default: res.echo_byte = CH_D;
        endcase
      end
      default: ;
    endcase
  end

  // A beat moves into the output register when it is free or being taken.
  assign load        = head_valid_i && (!out_valid_q || pop_i);
  assign head_pop_o  = load && res.last;
  assign beat_d      = load ? (res.last ? 2'd0 : beat_q + 2'd1) : beat_q;
  assign out_valid_d = load || (out_valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

endmodule

// File: hdl/serial_line_editor_core.sv
`timescale 1ns / 1ps
// Line input editor for a serial terminal.
// Input queue side: push with in_i (kind, rx_byte); full holds off new beats.
// Result queue side: empty low presents the oldest result on out_o; pop
// takes it. Each input yields one to four results; the last carries last=1.
// Results describe echo bytes to transmit and line buffer writes to perform.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 end character, 1 line buffer size) at the clock edge, no wait.
// The front classifies a byte and updates the line state in the cycle it is
// accepted and queues one order; one input is accepted per cycle while the
// order queue has room. The back drains orders at one result per cycle while
// the output register is free or being popped; the first result of an input
// reaches out_o by way of the order queue and the output register. An order
// stays at the queue head until its last result beat is loaded, so an input
// that causes the four-byte cursor-left echo holds back the next results.
// While the receiver holds pop low the output register and the queue fill,
// then full rises; nothing is lost.
// Reset clears the line state, the queue and the output valid flag, and loads
// end character 13 and line size 64.
module serial_line_editor_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  sle_pkg::in_t   in_i,
  output logic           empty,
  input  logic           pop,
  output sle_pkg::out_t  out_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [7:0]     cfg_wdata_i
);
  import sle_pkg::*;

  cmd_t cmd, head;
  logic accept, head_pop, q_full, q_empty;

  assign accept = push && !q_full;
  assign full   = q_full;

  sle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_i        (in_i),
    .cmd_o       (cmd)
  );

  sle_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd),
    .pop_i   (head_pop),
    .data_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_o        (out_o)
  );

  // An accepted input always leaves an order in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !q_empty)
    else $error("order queue empty after an accepted input");

  // The next beat of a multi-beat input follows without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_o.last) |=> !empty)
    else $error("gap inside a multi-beat result sequence");

  // The queue head is popped only on a final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |=> (!empty && out_o.last))
    else $error("order retired without its final result");

endmodule
